// File: rtl/ofd_pkg.sv
package ofd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CELL_W      = 8;
    localparam int INDEX_W     = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int LIMIT_W     = 7;
    localparam int CLASS_W     = 2;
    localparam int COLUMN_W    = 3 * CLASS_W;
    localparam int WINDOW_W    = 3 * COLUMN_W;

    localparam int MIN_SIZE        = 3;
    localparam int GRID_SIZE_RESET = 1024;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FREE_LIMIT  = 2'd2;

    localparam logic [LIMIT_W-1:0] FREE_LIMIT_RESET = 7'd25;

    localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;

    // Class bits of one cell.
    localparam int CLS_UNKNOWN_BIT = 0;
    localparam int CLS_FREE_BIT    = 1;

    localparam logic [WINDOW_W-1:0] NEIGH_UNKNOWN_MASK = 18'h15455;
    localparam int                  CENTRE_FREE_BIT    = 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COLUMN_W-1:0] column;   // top, middle and new class of one column
        logic                eval;     // window centre is an interior cell
        logic                last;     // window centre is the final interior cell
        logic [INDEX_W-1:0]  index;    // linear index of the window centre
    } t_column_item;

endpackage

// File: rtl/ofd_if.sv
interface ofd_cell_if;
    import ofd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] occupancy;

    modport source (output valid, output occupancy, input ready);
    modport sink   (input valid, input occupancy, output ready);
endinterface

interface ofd_result_if;
    import ofd_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] cell_index;
    logic               frontier_flag;
    logic               last;

    modport source (output valid, output cell_index, output frontier_flag, output last,
                    input ready);
    modport sink   (input valid, input cell_index, input frontier_flag, input last,
                    output ready);
endinterface

interface ofd_cfg_if;
    import ofd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ofd_front.sv
module ofd_front #(
    parameter int MAX_WIDTH  = ofd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ofd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ofd_cell_if.sink                          i_cell,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_height,
    input  logic [ofd_pkg::LIMIT_W-1:0]       i_free_limit,
    input  logic                              i_restart,
    output logic                              o_push,
    output ofd_pkg::t_column_item             o_item,
    input  logic                              i_push_ready
);
    import ofd_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);

    // Each entry holds the classes of the two rows above: {top, middle}.
    logic [2*CLASS_W-1:0] r_row_store [MAX_WIDTH];
    logic [2*CLASS_W-1:0] r_rd;

    logic [CB-1:0]      r_col;
    logic [RB-1:0]      r_row;
    logic [INDEX_W-1:0] r_idx;

    logic               r_f1_valid;
    logic [CLASS_W-1:0] r_f1_cls;
    logic [CB-1:0]      r_f1_col;
    logic               r_f1_eval;
    logic               r_f1_last;
    logic [INDEX_W-1:0] r_f1_idx;

    logic               accept;
    logic               col_end;
    logic               row_end;
    logic [CLASS_W-1:0] cls;

    // No item is taken while the counters return to the first cell of a new map.
    assign i_cell.ready = (!r_f1_valid || i_push_ready) && !i_restart;
    assign accept       = i_cell.valid && i_cell.ready;
    assign o_push       = r_f1_valid && i_push_ready;

    assign col_end = (WB'(r_col) == i_width - WB'(1));
    assign row_end = (HB'(r_row) == i_height - HB'(1));

    always_comb begin
        cls                  = '0;
        cls[CLS_UNKNOWN_BIT] = (i_cell.occupancy == CELL_UNKNOWN);
        cls[CLS_FREE_BIT]    = !i_cell.occupancy[CELL_W-1]
                               && (i_cell.occupancy[LIMIT_W-1:0] <= i_free_limit);
    end

    always_comb begin
        o_item.column = {r_rd, r_f1_cls};
        o_item.eval   = r_f1_eval;
        o_item.last   = r_f1_last;
        o_item.index  = r_f1_idx;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_row_store[r_col];
        end
        if (o_push) begin
            r_row_store[r_f1_col] <= {r_rd[CLASS_W-1:0], r_f1_cls};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_idx      <= '0;
            r_f1_valid <= 1'b0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (accept) begin
            r_f1_valid <= 1'b1;
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + RB'(1);
            end else begin
                r_col <= r_col + CB'(1);
            end
            r_idx <= (col_end && row_end) ? '0 : r_idx + INDEX_W'(1);
        end else if (o_push) begin
            r_f1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_cls  <= cls;
            r_f1_col  <= r_col;
            r_f1_eval <= (r_col >= CB'(2)) && (r_row >= RB'(2));
            r_f1_last <= col_end && row_end;
            // The centre sits one row up and one column left of the arriving cell.
            r_f1_idx  <= r_idx - INDEX_W'(i_width) - INDEX_W'(1);
        end
    end

endmodule

// File: rtl/ofd_queue.sv
module ofd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ofd_pkg::t_column_item i_item,
    output logic                  o_push_ready,
    output logic                  o_valid,
    output ofd_pkg::t_column_item o_item,
    input  logic                  i_pop
);
    import ofd_pkg::*;

    t_column_item        r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_cnt != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_item       = r_entry[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QUEUE_CW'(1);
            end
        end
    end

endmodule

// File: rtl/ofd_back.sv
module ofd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic                  i_valid,
    input  ofd_pkg::t_column_item i_item,
    output logic                  o_pop,
    ofd_result_if.source          o_result
);
    import ofd_pkg::*;

    logic [WINDOW_W-1:0] r_win;
    logic [WINDOW_W-1:0] n_win;
    logic                r_o_valid;
    logic [INDEX_W-1:0]  r_o_index;
    logic                r_o_frontier;
    logic                r_o_last;

    logic frontier;
    logic emit;

    assign o_pop    = i_valid && (!r_o_valid || o_result.ready);
    assign n_win    = {r_win[WINDOW_W-COLUMN_W-1:0], i_item.column};
    assign frontier = n_win[CENTRE_FREE_BIT] && ((n_win & NEIGH_UNKNOWN_MASK) != '0);
    assign emit     = i_item.eval && (frontier || i_item.last);

    assign o_result.valid         = r_o_valid;
    assign o_result.cell_index    = r_o_index;
    assign o_result.frontier_flag = r_o_frontier;
    assign o_result.last          = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_win <= '0;
            end else if (o_pop) begin
                r_win <= n_win;
            end
            // A pop only happens when the output register is free or being emptied.
            if (o_pop) begin
                r_o_valid <= emit;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_o_index    <= i_item.index;
            r_o_frontier <= frontier;
            r_o_last     <= i_item.last;
        end
    end

endmodule

// File: rtl/occupancy_frontier_detect_unit.sv
// Frontier detector for an occupancy grid streamed in raster order, one signed byte
// per item. The block takes one cell per clock unless the output stalls or a
// restart is pending, and gives at most one result per cell: the linear index of
// each free interior cell that has an unknown neighbour, plus one result with the
// last flag for the final interior cell of every map. A result passes through the
// front-end register, queue and output register; the two-entry queue between the
// classifying front end and the window evaluator, and the output register, let
// either side stall without losing the one-cell-per-clock rate. The row store is a
// MAX_WIDTH by 4-bit memory with one read and one write per cell; it is not cleared
// after reset, which is harmless as no window centre is evaluated before the first
// two rows of every map are stored. Writing the width or height restarts the map at
// its first cell and holds the cell input off meanwhile; the sizes are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT. Configure only while no items are in flight.
module occupancy_frontier_detect_unit #(
    parameter int MAX_WIDTH  = ofd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ofd_pkg::DEF_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ofd_cell_if.sink      i_cell,
    ofd_cfg_if.sink       i_cfg,
    ofd_result_if.source  o_result
);
    import ofd_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    localparam int WIDTH_RESET  = (MAX_WIDTH < GRID_SIZE_RESET) ? MAX_WIDTH : GRID_SIZE_RESET;
    localparam int HEIGHT_RESET = (MAX_HEIGHT < GRID_SIZE_RESET) ? MAX_HEIGHT
                                                                  : GRID_SIZE_RESET;

    logic [WB-1:0]      r_width;
    logic [HB-1:0]      r_height;
    logic [LIMIT_W-1:0] r_free_limit;
    logic               r_restart;

    logic         cfg_write;
    logic         q_push;
    logic         q_push_ready;
    logic         q_valid;
    logic         q_pop;
    t_column_item front_item;
    t_column_item back_item;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WB'(WIDTH_RESET);
            r_height     <= HB'(HEIGHT_RESET);
            r_free_limit <= FREE_LIMIT_RESET;
            r_restart    <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (cfg_write) begin
                unique case (i_cfg.index)
                    REG_GRID_WIDTH: begin
                        if (32'(i_cfg.data) < MIN_SIZE) begin
                            r_width <= WB'(MIN_SIZE);
                        end else if (32'(i_cfg.data) > MAX_WIDTH) begin
                            r_width <= WB'(MAX_WIDTH);
                        end else begin
                            r_width <= WB'(i_cfg.data);
                        end
                        r_restart <= 1'b1;
                    end
                    REG_GRID_HEIGHT: begin
                        if (32'(i_cfg.data) < MIN_SIZE) begin
                            r_height <= HB'(MIN_SIZE);
                        end else if (32'(i_cfg.data) > MAX_HEIGHT) begin
                            r_height <= HB'(MAX_HEIGHT);
                        end else begin
                            r_height <= HB'(i_cfg.data);
                        end
                        r_restart <= 1'b1;
                    end
                    REG_FREE_LIMIT: begin
                        r_free_limit <= i_cfg.data[LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    ofd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell       (i_cell),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_free_limit (r_free_limit),
        .i_restart    (r_restart),
        .o_push       (q_push),
        .o_item       (front_item),
        .i_push_ready (q_push_ready)
    );

    ofd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_item       (front_item),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_item       (back_item),
        .i_pop        (q_pop)
    );

    ofd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (r_restart),
        .i_valid   (q_valid),
        .i_item    (back_item),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

endmodule
